FILE: src/srle_pkg.sv
// shared types, constants and helper functions of the snapshot rle byte decoder
`default_nettype none

package srle_pkg;

    localparam int ADDR_BITS  = 18;
    localparam int OUT_ADDR_W = 18;
    localparam int MAX_RES    = 3;
    localparam int RES_N_W    = 2;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] ESC_BYTE = 8'hED;

    localparam logic [ADDR_BITS-1:0] START_ADDR  = ADDR_BITS'(32'h4000);
    localparam logic [ADDR_BITS-1:0] ADDR_P48_4  = ADDR_BITS'(32'h8000);
    localparam logic [ADDR_BITS-1:0] ADDR_P48_5  = ADDR_BITS'(32'hC000);
    localparam logic [ADDR_BITS-1:0] ADDR_P48_8  = ADDR_BITS'(32'h4000);
    localparam logic [ADDR_BITS-1:0] ADDR_P128_0 = ADDR_BITS'(32'h20000);
    localparam logic [ADDR_BITS-1:0] ADDR_P128_2 = ADDR_BITS'(32'h24000);

    // register indexes on the config port
    localparam logic REG_FORMAT_MODE  = 1'b0;
    localparam logic REG_MEMORY_MODEL = 1'b1;

    localparam logic FMT_STREAM  = 1'b0;
    localparam logic FMT_BLOCKED = 1'b1;
    localparam logic MM_48K      = 1'b0;
    localparam logic MM_128K     = 1'b1;

    typedef enum logic [5:0] {
        PH_START  = 6'b000001,
        PH_LEN_LO = 6'b000010,
        PH_LEN_HI = 6'b000100,
        PH_PAGE   = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_DONE   = 6'b100000
    } t_phase;

    typedef struct packed {
        t_phase                phase;
        logic [23:0]           held_bytes;
        logic [1:0]            held_count;
        logic [ADDR_BITS-1:0]  next_address;
        logic [15:0]           block_remaining;
        logic                  finished;
    } t_state;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] write_address;
        logic [7:0]            fill_value;
        logic [7:0]            repeat_count;
        logic                  end_of_data;
        logic                  last_result;
    } t_result;

    // byte i of a four byte window, zero past the end
    function automatic logic [7:0] pick(input logic [31:0] v, input logic [2:0] i);
        logic [7:0] b;
        b = i[2] ? 8'h00 : v[{i[1:0], 3'b000} +: 8];
        return b;
    endfunction

    function automatic logic [OUT_ADDR_W-1:0] out_addr(input logic [ADDR_BITS-1:0] a);
        logic [19:0] w;
        w = 20'(a);
        return w[OUT_ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_BITS-1:0] map_page(input logic                 mm,
                                                      input logic [7:0]           page,
                                                      input logic [ADDR_BITS-1:0] cur);
        logic [ADDR_BITS-1:0] a;
        logic [7:0]           rel;
        a   = cur;
        rel = page - 8'd3;
        if (mm == MM_48K) begin
            case (page)
                8'd4:    a = ADDR_P48_4;
                8'd5:    a = ADDR_P48_5;
                8'd8:    a = ADDR_P48_8;
                default: a = '0;
            endcase
        end else begin
            if (page == 8'd0) begin
                a = ADDR_P128_0;
            end else if (page == 8'd2) begin
                a = ADDR_P128_2;
            end else if (page >= 8'd3 && page <= 8'd10) begin
                a = ADDR_BITS'({rel[2:0], 14'b0});
            end
        end
        return a;
    endfunction

endpackage

`default_nettype wire

FILE: src/srle_step.sv
// next state and write runs for one accepted byte
`default_nettype none

module srle_step import srle_pkg::*; (
    input  wire t_state                i_state,
    input  wire logic                  i_format_mode,
    input  wire logic                  i_memory_model,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_section_start,
    output t_state                     o_state,
    output t_result [MAX_RES-1:0]      o_res,
    output logic [RES_N_W-1:0]         o_res_n
);

    t_state                s;
    t_result [MAX_RES-1:0] res;
    logic [RES_N_W-1:0]    nres;
    logic [31:0]           qv;
    logic [31:0]           qv_sh;
    logic [2:0]            cnt;
    logic [2:0]            h;
    logic [2:0]            rem;
    logic [ADDR_BITS-1:0]  a;
    logic [7:0]            b0, b1, b2, b3;
    logic                  stop, last, fin, blk;
    logic                  do_emit;
    logic [7:0]            e_val, e_cnt, adv;
    logic                  e_end;

    always_comb begin
        s       = i_state;
        res     = '0;
        nres    = '0;
        qv      = '0;
        qv_sh   = '0;
        cnt     = '0;
        h       = '0;
        rem     = '0;
        a       = '0;
        b0      = '0;
        b1      = '0;
        b2      = '0;
        b3      = '0;
        stop    = 1'b0;
        last    = 1'b0;
        fin     = 1'b0;
        blk     = (i_format_mode == FMT_BLOCKED);
        do_emit = 1'b0;
        e_val   = '0;
        e_cnt   = '0;
        e_end   = 1'b0;
        adv     = '0;

        if (i_section_start) begin
            s.phase           = PH_START;
            s.held_bytes      = '0;
            s.held_count      = '0;
            s.next_address    = START_ADDR;
            s.block_remaining = '0;
            s.finished        = 1'b0;
        end
        if (s.phase == PH_START) begin
            s.phase = blk ? PH_LEN_LO : PH_DATA;
        end

        if (s.finished) begin
            s.phase = PH_DONE;
        end else begin
            case (s.phase)
                PH_LEN_LO: begin
                    s.block_remaining = {8'h00, i_data_byte};
                    s.phase           = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    s.block_remaining = {i_data_byte, s.block_remaining[7:0]};
                    s.phase           = PH_PAGE;
                end
                PH_PAGE: begin
                    s.next_address = map_page(i_memory_model, i_data_byte, s.next_address);
                    s.phase        = (s.block_remaining != 16'd0) ? PH_DATA : PH_LEN_LO;
                end
                PH_DATA: begin
                    qv = {8'h00, s.held_bytes};
                    qv[{s.held_count, 3'b000} +: 8] = i_data_byte;
                    cnt = {1'b0, s.held_count} + 3'd1;
                    if (blk) begin
                        if (s.block_remaining <= 16'd1) begin
                            last              = 1'b1;
                            s.block_remaining = '0;
                        end else begin
                            s.block_remaining = s.block_remaining - 16'd1;
                        end
                    end
                    a = s.next_address;

                    // at most four decisions, each one consumes at least one byte or stops
                    for (int it = 0; it < 4; it++) begin
                        if (!stop && h < cnt) begin
                            rem     = cnt - h;
                            b0      = pick(qv, h);
                            b1      = pick(qv, h + 3'd1);
                            b2      = pick(qv, h + 3'd2);
                            b3      = pick(qv, h + 3'd3);
                            do_emit = 1'b0;
                            e_val   = b0;
                            e_cnt   = 8'd1;
                            e_end   = 1'b0;
                            adv     = 8'd1;
                            if (b0 == ESC_BYTE) begin
                                if (rem == 3'd1) begin
                                    stop = 1'b1;
                                end else if (b1 != ESC_BYTE) begin
                                    do_emit = 1'b1;
                                    h       = h + 3'd1;
                                end else if (rem < 3'd4) begin
                                    stop = 1'b1;
                                end else begin
                                    // run of b2 copies of b3, none for a zero count
                                    do_emit = (b2 != 8'd0);
                                    e_val   = b3;
                                    e_cnt   = b2;
                                    adv     = b2;
                                    h       = h + 3'd4;
                                end
                            end else if (!blk && b0 == 8'd0) begin
                                if (rem == 3'd1) begin
                                    stop = 1'b1;
                                end else if (b1 != ESC_BYTE) begin
                                    do_emit = 1'b1;
                                    h       = h + 3'd1;
                                end else if (rem == 3'd2) begin
                                    stop = 1'b1;
                                end else if (b2 != ESC_BYTE) begin
                                    do_emit = 1'b1;
                                    h       = h + 3'd1;
                                end else if (rem == 3'd3) begin
                                    stop = 1'b1;
                                end else if (b3 != 8'd0) begin
                                    do_emit = 1'b1;
                                    h       = h + 3'd1;
                                end else begin
                                    // end marker
                                    do_emit = 1'b1;
                                    e_val   = 8'd0;
                                    e_cnt   = 8'd0;
                                    e_end   = 1'b1;
                                    adv     = 8'd0;
                                    fin     = 1'b1;
                                    s.phase = PH_DONE;
                                    h       = cnt;
                                end
                            end else begin
                                do_emit = 1'b1;
                                h       = h + 3'd1;
                            end
                            if (!stop) begin
                                if (do_emit && nres != RES_N_W'(MAX_RES)) begin
                                    res[nres] = '{write_address: out_addr(a),
                                                  fill_value:    e_val,
                                                  repeat_count:  e_cnt,
                                                  end_of_data:   e_end,
                                                  last_result:   1'b0};
                                end
                                if (do_emit && nres != RES_N_W'(MAX_RES)) begin
                                    nres = nres + 1'b1;
                                end
                                a = a + ADDR_BITS'(adv);
                            end
                        end
                    end

                    // block end: whatever is still held goes out as literals
                    if (last && !fin) begin
                        for (int k = 0; k < 4; k++) begin
                            if (3'(k) >= h && 3'(k) < cnt) begin
                                if (nres != RES_N_W'(MAX_RES)) begin
                                    res[nres] = '{write_address: out_addr(a),
                                                  fill_value:    pick(qv, 3'(k)),
                                                  repeat_count:  8'd1,
                                                  end_of_data:   1'b0,
                                                  last_result:   1'b0};
                                    nres = nres + 1'b1;
                                end
                                a = a + ADDR_BITS'(1);
                            end
                        end
                        h       = cnt;
                        s.phase = PH_LEN_LO;
                    end

                    qv_sh          = qv >> {h, 3'b000};
                    s.held_count   = 2'(cnt - h);
                    s.held_bytes   = qv_sh[23:0];
                    s.next_address = a;
                    s.finished     = fin;
                end
                default: ;
            endcase
        end

        if (nres != '0) begin
            res[nres - 1'b1].last_result = 1'b1;
        end
    end

    assign o_state = s;
    assign o_res   = res;
    assign o_res_n = nres;

endmodule

`default_nettype wire

FILE: src/srle_queue.sv
// small result queue: takes up to three runs per cycle, gives one per cycle while i_pop is high
`default_nettype none

module srle_queue import srle_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire t_result [MAX_RES-1:0] i_res,
    input  wire logic [RES_N_W-1:0]    i_res_n,
    input  wire logic                  i_pop,
    output logic                       o_room,
    output logic                       o_valid,
    output t_result                    o_head
);

    t_result               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]    r_count, n_count;
    logic [Q_CNT_W-1:0]    push_n;
    logic                  pop_en;

    assign push_n   = i_push ? Q_CNT_W'(i_res_n) : '0;
    assign pop_en   = i_pop && (r_count != '0);
    assign n_wr_ptr = r_wr_ptr + Q_PTR_W'(push_n);
    assign n_rd_ptr = r_rd_ptr + Q_PTR_W'(pop_en);
    assign n_count  = r_count + push_n - Q_CNT_W'(pop_en);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_RES; j++) begin
            if (Q_CNT_W'(j) < push_n) begin
                r_mem[r_wr_ptr + Q_PTR_W'(j)] <= i_res[j];
            end
        end
    end

    // room for the worst case of one byte
    assign o_room  = (r_count <= Q_CNT_W'(Q_DEPTH - MAX_RES));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

FILE: src/snapshot_rle_byte_decoder.sv
// top level: snapshot rle byte decoder with config registers and result queue
//
// usage:
//   input channel  i_in_valid / o_in_stall carries one byte of the compressed
//   memory section plus a section start flag; i_section_start restarts parsing
//   on that byte. output channel o_out_valid / i_out_stall carries write runs
//   (address, fill value, repeat count, end of data flag, last result flag).
//   the apb port holds format_mode at 0x0 and memory_model at 0x4; write them
//   only while no item is in flight.
//   the runs of an accepted byte are registered in the queue. throughput: one
//   byte per cycle when not stalled; a byte is decoded combinationally against
//   the parse state. a byte gives up to three runs, drained one per cycle from
//   a four entry queue, so the input stalls while more than one run waits.
//   receiver stall: the head run holds steady and the queue fills; the input
//   side then stalls until there is room for three runs.
//   reset: parse state goes to the start of a single stream section at address
//   0x4000, both config registers clear, the queue empties.
`default_nettype none

module snapshot_rle_byte_decoder import srle_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_section_start,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [OUT_ADDR_W-1:0]      o_write_address,
    output logic [7:0]                 o_fill_value,
    output logic [7:0]                 o_repeat_count,
    output logic                       o_end_of_data,
    output logic                       o_last_result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic                  r_format_mode;
    logic                  r_memory_model;
    t_state                r_state;
    t_state                n_state;
    t_result [MAX_RES-1:0] step_res;
    logic [RES_N_W-1:0]    step_res_n;
    logic                  in_acc;
    logic                  q_room;
    logic                  cfg_wr;
    t_result               head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_MEMORY_MODEL) ? {31'b0, r_memory_model}
                                                  : {31'b0, r_format_mode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_mode  <= 1'b0;
            r_memory_model <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FORMAT_MODE:  r_format_mode  <= pwdata[0];
                REG_MEMORY_MODEL: r_memory_model <= pwdata[0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = !q_room;
    assign in_acc     = i_in_valid && !o_in_stall;

    srle_step u_step (
        .i_state         (r_state),
        .i_format_mode   (r_format_mode),
        .i_memory_model  (r_memory_model),
        .i_data_byte     (i_data_byte),
        .i_section_start (i_section_start),
        .o_state         (n_state),
        .o_res           (step_res),
        .o_res_n         (step_res_n)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase           <= PH_START;
            r_state.held_bytes      <= '0;
            r_state.held_count      <= '0;
            r_state.next_address    <= START_ADDR;
            r_state.block_remaining <= '0;
            r_state.finished        <= 1'b0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    srle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_acc),
        .i_res   (step_res),
        .i_res_n (step_res_n),
        .i_pop   (!i_out_stall),
        .o_room  (q_room),
        .o_valid (o_out_valid),
        .o_head  (head)
    );

    assign o_write_address = head.write_address;
    assign o_fill_value    = head.fill_value;
    assign o_repeat_count  = head.repeat_count;
    assign o_end_of_data   = head.end_of_data;
    assign o_last_result   = head.last_result;

    // once the end marker is seen only a section start wakes the parser
    a_finished_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_state.finished && !i_section_start |=> r_state.finished)
        else $error("finished parser left the done phase without a section start");

    a_finished_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.finished |-> r_state.phase == PH_DONE)
        else $error("finished flag set outside the done phase");

    // the input only stalls while runs are waiting
    a_stall_needs_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with an empty result queue");

endmodule

`default_nettype wire
